FILE: design/mpeg2_header_field_parser_core_assert.svh
// assertion macros for the header field parser
`ifndef MPEG2_HEADER_FIELD_PARSER_CORE_ASSERT_SVH
`define MPEG2_HEADER_FIELD_PARSER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MHFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define MHFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mhfp_pkg.sv
`timescale 1ns / 1ps
package mhfp_pkg;

  localparam int QueueDepth = 4;
  localparam int ResultsMax = 8;

  typedef enum logic [1:0] {
    KIND_SEQ  = 2'd0,
    KIND_EXT  = 2'd1,
    KIND_PIC  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_FIXED  = 3'd0,
    PH_BODY   = 3'd1,
    PH_IFLAG  = 3'd4,
    PH_IMAT   = 3'd5,
    PH_NFLAG  = 3'd6,
    PH_NMAT   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERRUN  = 3'd1,
    ST_ZERO     = 3'd2,
    ST_BADTYPE  = 3'd3,
    ST_SCALABLE = 3'd4
  } status_t;

  localparam logic [4:0] FC_WIDTH     = 5'd1;
  localparam logic [4:0] FC_HEIGHT    = 5'd2;
  localparam logic [4:0] FC_ASPECT    = 5'd3;
  localparam logic [4:0] FC_RATE      = 5'd4;
  localparam logic [4:0] FC_IENTRY    = 5'd5;
  localparam logic [4:0] FC_NENTRY    = 5'd6;
  localparam logic [4:0] FC_IDEF      = 5'd7;
  localparam logic [4:0] FC_NDEF      = 5'd8;
  localparam logic [4:0] FC_PROFILE   = 5'd9;
  localparam logic [4:0] FC_PROG      = 5'd10;
  localparam logic [4:0] FC_CHROMA    = 5'd11;
  localparam logic [4:0] FC_LOWDELAY  = 5'd12;
  localparam logic [4:0] FC_MATCOEF   = 5'd13;
  localparam logic [4:0] FC_FCODE     = 5'd14;
  localparam logic [4:0] FC_DCPREC    = 5'd15;
  localparam logic [4:0] FC_PICSTRUCT = 5'd16;
  localparam logic [4:0] FC_FPFD      = 5'd17;
  localparam logic [4:0] FC_CONCEAL   = 5'd18;
  localparam logic [4:0] FC_QSCALE    = 5'd19;
  localparam logic [4:0] FC_VLC       = 5'd20;
  localparam logic [4:0] FC_ALTSCAN   = 5'd21;
  localparam logic [4:0] FC_EXTID     = 5'd22;
  localparam logic [4:0] FC_TEMPREF   = 5'd23;
  localparam logic [4:0] FC_PTYPE     = 5'd24;
  localparam logic [4:0] FC_STATUS    = 5'd31;

  localparam logic [3:0] EXT_SEQ     = 4'd1;
  localparam logic [3:0] EXT_DISP    = 4'd2;
  localparam logic [3:0] EXT_QMAT    = 4'd3;
  localparam logic [3:0] EXT_SPSCAL  = 4'd5;
  localparam logic [3:0] EXT_PICCOD  = 4'd8;
  localparam logic [3:0] EXT_TEMPSC  = 4'd9;
  localparam logic [3:0] EXT_SNR     = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] header_kind;
    logic       first_byte;
    logic       final_byte;
    logic       sequence_known;
    logic       picture_known;
  } item_t;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [5:0]  entry_index;
    logic [13:0] field_value;
    logic [2:0]  status;
    logic        run_last;
  } result_t;

  function automatic logic [5:0] scan_pos(input logic [5:0] k);
    logic [5:0] p;
    case (k)
      6'd0: p = 6'd0;   6'd1: p = 6'd1;   6'd2: p = 6'd8;   6'd3: p = 6'd16;
      6'd4: p = 6'd9;   6'd5: p = 6'd2;   6'd6: p = 6'd3;   6'd7: p = 6'd10;
      6'd8: p = 6'd17;  6'd9: p = 6'd24;  6'd10: p = 6'd32; 6'd11: p = 6'd25;
      6'd12: p = 6'd18; 6'd13: p = 6'd11; 6'd14: p = 6'd4;  6'd15: p = 6'd5;
      6'd16: p = 6'd12; 6'd17: p = 6'd19; 6'd18: p = 6'd26; 6'd19: p = 6'd33;
      6'd20: p = 6'd40; 6'd21: p = 6'd48; 6'd22: p = 6'd41; 6'd23: p = 6'd34;
      6'd24: p = 6'd27; 6'd25: p = 6'd20; 6'd26: p = 6'd13; 6'd27: p = 6'd6;
      6'd28: p = 6'd7;  6'd29: p = 6'd14; 6'd30: p = 6'd21; 6'd31: p = 6'd28;
      6'd32: p = 6'd35; 6'd33: p = 6'd42; 6'd34: p = 6'd49; 6'd35: p = 6'd56;
      6'd36: p = 6'd57; 6'd37: p = 6'd50; 6'd38: p = 6'd43; 6'd39: p = 6'd36;
      6'd40: p = 6'd29; 6'd41: p = 6'd22; 6'd42: p = 6'd15; 6'd43: p = 6'd23;
      6'd44: p = 6'd30; 6'd45: p = 6'd37; 6'd46: p = 6'd44; 6'd47: p = 6'd51;
      6'd48: p = 6'd58; 6'd49: p = 6'd59; 6'd50: p = 6'd52; 6'd51: p = 6'd45;
      6'd52: p = 6'd38; 6'd53: p = 6'd31; 6'd54: p = 6'd39; 6'd55: p = 6'd46;
      6'd56: p = 6'd53; 6'd57: p = 6'd60; 6'd58: p = 6'd61; 6'd59: p = 6'd54;
      6'd60: p = 6'd47; 6'd61: p = 6'd55; 6'd62: p = 6'd62; default: p = 6'd63;
    endcase
    return p;
  endfunction

endpackage

FILE: design/mpeg2_header_field_parser_core.sv
`timescale 1ns / 1ps
// Header field parser: body bytes enter through a short queue; the parser takes a
// byte only once the last one is done and walks it one bit a cycle, and a final
// byte adds a closing step for the status result. Results leave through a one-entry
// output register, up to eight per byte plus a final byte's status result; a
// receiver stall holds the walk, and run_last marks a byte's last result.
module mpeg2_header_field_parser_core
  import mhfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [4:0]  s_tuser,   // header_kind, first_byte, sequence_known, picture_known
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // field_code, entry_index, field_value, status
  output logic        m_tlast    // run_last
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t r;

  assign in_item = '{data_byte: s_tdata, header_kind: s_tuser[1:0], first_byte: s_tuser[2],
                     final_byte: s_tlast, sequence_known: s_tuser[3],
                     picture_known: s_tuser[4]};

  mhfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  mhfp_engine u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(r)
  );

  assign m_tdata = {4'd0, r.status, r.field_value, r.entry_index, r.field_code};
  assign m_tlast = r.run_last;

endmodule

FILE: design/mhfp_queue.sv
`timescale 1ns / 1ps
module mhfp_queue
  import mhfp_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic push;
  logic pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

FILE: design/mhfp_engine.sv
`timescale 1ns / 1ps
module mhfp_engine
  import mhfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  `include "mpeg2_header_field_parser_core_assert.svh"

  // per-byte walker: one bit per cycle unless the receiver stalls, results through an output register
  logic        busy;
  logic [3:0]  bit_cnt;
  logic        closing;
  item_t       cur;
  logic [10:0] bit_position;
  kind_t       kind_held;
  logic [3:0]  extension_id;
  logic [15:0] field_accumulator;
  logic [13:0] picture_width;
  logic [13:0] picture_height;
  phase_t      matrix_phase;
  logic [1:0]  gate_flags;
  logic        pend_valid;
  result_t     pend;

  logic [10:0] bit_position_next;
  kind_t       kind_held_next;
  logic [3:0]  extension_id_next;
  logic [15:0] field_accumulator_next;
  logic [13:0] picture_width_next;
  logic [13:0] picture_height_next;
  phase_t      matrix_phase_next;
  logic [1:0]  gate_flags_next;
  logic        pend_valid_next;
  logic        emit;
  result_t     emit_res;
  logic        stall;
  logic        b;
  logic [15:0] acc;
  logic [10:0] n;
  logic        matched;
  logic [2:0]  st;
  logic        last_bit;
  logic        run_flag;
  logic        prev_res;

  assign stall    = pend_valid && res_valid && !res_ready;
  assign in_ready = !busy && !stall;
  assign b        = cur.data_byte[3'd7 - bit_cnt[2:0]];
  assign acc      = {field_accumulator[14:0], b};
  assign n        = bit_position + 11'd1;
  assign last_bit = (bit_cnt == 4'd7);

  task automatic go(input phase_t p);
    matrix_phase_next      = p;
    bit_position_next      = '0;
    field_accumulator_next = '0;
  endtask

  task automatic put(input logic [4:0] c, input logic [5:0] i, input logic [13:0] x);
    emit = 1'b1;
    emit_res = '{field_code: c, entry_index: i, field_value: x, status: 3'd0, run_last: 1'b0};
  endtask

  always_comb begin
    bit_position_next      = bit_position;
    kind_held_next         = kind_held;
    extension_id_next      = extension_id;
    field_accumulator_next = field_accumulator;
    picture_width_next     = picture_width;
    picture_height_next    = picture_height;
    matrix_phase_next      = matrix_phase;
    gate_flags_next        = gate_flags;
    emit     = 1'b0;
    emit_res = '0;
    matched  = 1'b0;
    st       = ST_OK;
    if (busy && !closing && gate_flags[0] && !gate_flags[1]) begin
      field_accumulator_next = acc;
      bit_position_next      = n;
      case (matrix_phase)
        PH_IFLAG: go(b ? PH_IMAT : PH_NFLAG);
        PH_NFLAG: begin
          if (b) begin
            go(PH_NMAT);
          end else begin
            if (kind_held == KIND_SEQ) put(FC_NDEF, 6'd0, 14'd16);
            gate_flags_next[1] = 1'b1;
          end
        end
        PH_IMAT, PH_NMAT: begin
          if (n[2:0] == 3'd0) begin
            put((matrix_phase == PH_IMAT) ? FC_IENTRY : FC_NENTRY,
                scan_pos(n[8:3] - 6'd1), {6'd0, acc[7:0]});
            field_accumulator_next = '0;
          end
          if (n >= 11'd512) begin
            if (matrix_phase == PH_IMAT) go(PH_NFLAG);
            else gate_flags_next[1] = 1'b1;
          end
        end
        default: begin
          if (kind_held == KIND_SEQ && matrix_phase == PH_FIXED) begin
            matched = 1'b1;
            case (n)
              11'd12: begin
                picture_width_next = {2'd0, acc[11:0]};
                put(FC_WIDTH, 6'd0, {2'd0, acc[11:0]});
              end
              11'd24: begin
                picture_height_next = {2'd0, acc[11:0]};
                put(FC_HEIGHT, 6'd0, {2'd0, acc[11:0]});
              end
              11'd28: put(FC_ASPECT, 6'd0, {10'd0, acc[3:0]});
              11'd32: put(FC_RATE, 6'd0, {10'd0, acc[3:0]});
              11'd50, 11'd51, 11'd61, 11'd62: ;
              11'd63: begin
                if (b) go(PH_IMAT);
                else begin
                  put(FC_IDEF, 6'd0, 14'd0);
                  go(PH_NFLAG);
                end
              end
              default: matched = 1'b0;
            endcase
            if (matched && n != 11'd63) field_accumulator_next = '0;
          end else if (kind_held == KIND_EXT && matrix_phase == PH_FIXED) begin
            if (n == 11'd4) begin
              extension_id_next = acc[3:0];
              put(FC_EXTID, 6'd0, {10'd0, acc[3:0]});
              if ((acc[3:0] == EXT_SEQ || acc[3:0] == EXT_DISP) && cur.sequence_known)
                go(PH_BODY);
              else if (acc[3:0] == EXT_PICCOD && cur.picture_known) go(PH_BODY);
              else if (acc[3:0] == EXT_QMAT) go(PH_IFLAG);
              else gate_flags_next[1] = 1'b1;
            end
          end else if (kind_held == KIND_EXT && matrix_phase == PH_BODY &&
                       extension_id == EXT_SEQ) begin
            matched = 1'b1;
            case (n)
              11'd8:  put(FC_PROFILE, 6'd0, {6'd0, acc[7:0]});
              11'd9:  put(FC_PROG, 6'd0, {13'd0, acc[0]});
              11'd11: put(FC_CHROMA, 6'd0, {12'd0, acc[1:0]});
              11'd13: begin
                picture_width_next = picture_width | {acc[1:0], 12'd0};
                put(FC_WIDTH, 6'd0, picture_width | {acc[1:0], 12'd0});
              end
              11'd15: begin
                picture_height_next = picture_height | {acc[1:0], 12'd0};
                put(FC_HEIGHT, 6'd0, picture_height | {acc[1:0], 12'd0});
              end
              11'd27, 11'd28, 11'd36: ;
              11'd37: put(FC_LOWDELAY, 6'd0, {13'd0, acc[0]});
              11'd44: gate_flags_next[1] = 1'b1;
              default: matched = 1'b0;
            endcase
            if (matched) field_accumulator_next = '0;
          end else if (kind_held == KIND_EXT && matrix_phase == PH_BODY &&
                       extension_id == EXT_DISP) begin
            matched = 1'b1;
            case (n)
              11'd3, 11'd12, 11'd20: ;
              11'd4: if (!acc[0]) gate_flags_next[1] = 1'b1;
              11'd28: begin
                put(FC_MATCOEF, 6'd0, {6'd0, acc[7:0]});
                gate_flags_next[1] = 1'b1;
              end
              default: matched = 1'b0;
            endcase
            if (matched) field_accumulator_next = '0;
          end else if (kind_held == KIND_EXT && matrix_phase == PH_BODY &&
                       extension_id == EXT_PICCOD) begin
            matched = 1'b1;
            case (n)
              11'd4:  put(FC_FCODE, 6'd0, {10'd0, acc[3:0]});
              11'd8:  put(FC_FCODE, 6'd1, {10'd0, acc[3:0]});
              11'd12: put(FC_FCODE, 6'd2, {10'd0, acc[3:0]});
              11'd16: put(FC_FCODE, 6'd3, {10'd0, acc[3:0]});
              11'd18: put(FC_DCPREC, 6'd0, {12'd0, acc[1:0]});
              11'd20: put(FC_PICSTRUCT, 6'd0, {12'd0, acc[1:0]});
              11'd21: ;
              11'd22: put(FC_FPFD, 6'd0, {13'd0, acc[0]});
              11'd23: put(FC_CONCEAL, 6'd0, {13'd0, acc[0]});
              11'd24: put(FC_QSCALE, 6'd0, {13'd0, acc[0]});
              11'd25: put(FC_VLC, 6'd0, {13'd0, acc[0]});
              11'd26: begin
                put(FC_ALTSCAN, 6'd0, {13'd0, acc[0]});
                gate_flags_next[1] = 1'b1;
              end
              default: matched = 1'b0;
            endcase
            if (matched) field_accumulator_next = '0;
          end else if (kind_held == KIND_PIC && matrix_phase == PH_FIXED) begin
            matched = 1'b1;
            case (n)
              11'd10: put(FC_TEMPREF, 6'd0, {4'd0, acc[9:0]});
              11'd13: begin
                extension_id_next = {1'b0, acc[2:0]};
                put(FC_PTYPE, 6'd0, {11'd0, acc[2:0]});
              end
              11'd29: gate_flags_next[1] = 1'b1;
              default: matched = 1'b0;
            endcase
            if (matched) field_accumulator_next = '0;
          end else begin
            gate_flags_next[1] = 1'b1;
          end
        end
      endcase
    end else if (busy && closing) begin
      if (kind_held == KIND_EXT && (extension_id == EXT_SPSCAL ||
          extension_id == EXT_TEMPSC || extension_id == EXT_SNR))
        st = ST_SCALABLE;
      else if (!gate_flags[1])
        st = (kind_held == KIND_EXT && matrix_phase == PH_BODY &&
              extension_id == EXT_DISP) ? ST_OK : ST_OVERRUN;
      else if (kind_held == KIND_SEQ && (picture_width[11:0] == 12'd0 ||
               picture_height[11:0] == 12'd0))
        st = ST_ZERO;
      else if (kind_held == KIND_PIC && (extension_id < 4'd1 || extension_id > 4'd3))
        st = ST_BADTYPE;
      emit = 1'b1;
      emit_res = '{field_code: FC_STATUS, entry_index: 6'd0, field_value: 14'd0,
                   status: st, run_last: 1'b0};
      gate_flags_next = '0;
    end
  end

  // the last result of a byte is only known once the byte is finished, so the
  // newest result waits in pend and is flagged when the byte's walk ends
  assign run_flag = busy && (closing || (last_bit && !cur.final_byte));

  assign res_valid = pend_valid && (busy ? (emit || run_flag) : 1'b1);
  assign prev_res  = pend_valid;
  always_comb begin
    res = pend;
    res.run_last = !busy || (run_flag && !emit);
  end

  always_comb begin
    pend_valid_next = pend_valid;
    if (res_valid && res_ready) pend_valid_next = 1'b0;
    if (emit) pend_valid_next = 1'b1;
    else if (run_flag) pend_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      bit_cnt           <= '0;
      closing           <= 1'b0;
      bit_position      <= '0;
      kind_held         <= KIND_SEQ;
      extension_id      <= '0;
      field_accumulator <= '0;
      picture_width     <= '0;
      picture_height    <= '0;
      matrix_phase      <= PH_FIXED;
      gate_flags        <= '0;
      pend_valid        <= 1'b0;
    end else if (!stall) begin
      pend_valid <= pend_valid_next;
      if (!busy) begin
        if (in_valid) begin
          cur <= in_item;
          bit_cnt <= '0;
          closing <= 1'b0;
          if (in_item.first_byte) begin
            busy              <= 1'b1;
            gate_flags        <= {(in_item.header_kind == KIND_NONE), 1'b1};
            kind_held         <= kind_t'(in_item.header_kind);
            extension_id      <= '0;
            matrix_phase      <= PH_FIXED;
            bit_position      <= '0;
            field_accumulator <= '0;
          end else begin
            busy <= gate_flags[0];
          end
        end
      end else begin
        bit_position      <= bit_position_next;
        kind_held         <= kind_held_next;
        extension_id      <= extension_id_next;
        field_accumulator <= field_accumulator_next;
        picture_width     <= picture_width_next;
        picture_height    <= picture_height_next;
        matrix_phase      <= matrix_phase_next;
        gate_flags        <= gate_flags_next;
        if (emit) begin
          pend <= emit_res;
        end
        if (closing) begin
          busy <= 1'b0;
        end else if (last_bit) begin
          if (cur.final_byte) closing <= 1'b1;
          else busy <= 1'b0;
        end else begin
          bit_cnt <= bit_cnt + 4'd1;
        end
      end
    end
  end

  `MHFP_ASSERT_IMP(a_status_last, busy && closing && res_valid, res.field_code != FC_STATUS,
    "status result left before the byte closed")
  `MHFP_ASSERT_NEXT(a_close_idle, busy && closing && !stall, !gate_flags[0],
    "header still active after its final byte")
  `MHFP_ASSERT_IMP(a_cnt_range, busy, bit_cnt <= 4'd7, "bit counter out of range")
  `MHFP_ASSERT_IMP(a_prev_hold, stall, prev_res, "stall without a held result")

endmodule
